// ----- hdl/cmtp_pkg.sv -----
// shared types, constants and helpers of the cue marker tag parser
package cmtp_pkg;

  localparam int CUE_SLOTS   = 5;
  localparam int LOOP_SLOTS  = 9;
  localparam int TOTAL_SLOTS = CUE_SLOTS + LOOP_SLOTS;
  localparam int SLOT_W      = $clog2(TOTAL_SLOTS + 1);

  localparam int ENTRY_PACKED = 22;
  localparam int ENTRY_PLAIN  = 19;
  localparam int CNT_W        = 5;
  localparam int HDR_LAST     = 5;
  localparam int TRL_LAST     = 3;

  localparam logic [15:0] TAG_VERSION = 16'h0205;
  localparam logic [31:0] NO_POS      = 32'h7F7F7F7F;
  localparam logic [7:0]  ABSENT_MARK = 8'h7F;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } res_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_VERSION  = 4'd1,
    ERR_COUNT    = 4'd2,
    ERR_START    = 4'd3,
    ERR_END      = 4'd4,
    ERR_FILLER   = 4'd5,
    ERR_LOCK     = 4'd6,
    ERR_SLOT     = 4'd7,
    ERR_TRUNC    = 4'd8,
    ERR_TRAILING = 4'd9,
    ERR_PAD      = 4'd10
  } err_code_e;

  typedef enum logic [1:0] {
    REG_FORMAT_MODE = 2'd0,
    REG_CUE_TYPE    = 2'd1,
    REG_LOOP_TYPE   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic       format_mode;
    logic [7:0] cue_type_code;
    logic [7:0] loop_type_code;
  } cfg_t;

  typedef struct packed {
    res_kind_e   result_kind;
    logic [3:0]  slot_index;
    logic        has_start;
    logic [31:0] start_position;
    logic        has_end;
    logic [31:0] end_position;
    logic [23:0] marker_color;
    logic [7:0]  type_code;
    logic        locked_flag;
    logic [23:0] track_color;
    err_code_e   error_code;
  } res_t;

  // four 7-bit groups folded into 24 bits, top bits of the first byte dropped
  function automatic logic [23:0] unpack24(input logic [7:0] w, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] z);
    unpack24 = {w[2:0], x[6:2], x[1:0], y[6:1], y[0], z[6:0]};
  endfunction

endpackage

// ----- hdl/cue_marker_tag_parser.sv -----
// cue marker tag parser top level: stream ports, register port, parser and output buffer
//
// Bytes of a marker tag enter on the s_axis channel, one byte per transfer,
// with s_axis_tlast on the final byte of the tag. Each completed entry gives
// one result on the m_axis channel, the trailer gives a final result with the
// track color, and any fault gives one error result after which bytes are
// dropped up to and including the last byte of the tag.
// The m_axis_tuser field holds the result kind; m_axis_tdata holds the rest.
// The parser takes one byte per cycle while s_axis_tready is high; its state
// registers are updated on every transfer and the result register follows them.
// When m_axis stalls, one further result is held in a skid entry; after that
// s_axis_tready drops until the output drains.
// Reset clears the parse state to the header and the registers to packed
// layout, cue type 1 and loop type 3. Registers are written over the APB
// port at byte addresses 0, 4 and 8; they must be changed only while idle, which the block does not enforce.
module cue_marker_tag_parser
  import cmtp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,
  // stream output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] slot_index, [4] has_start, [36:5] start_position, [37] has_end,
  // [69:38] end_position, [93:70] marker_color, [101:94] type_code,
  // [102] locked_flag, [126:103] track_color, [130:127] error_code, rest zero
  output logic [135:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] result_kind
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t  cfg_q;
  logic  advance;
  logic  res_valid, buf_ready;
  res_t  res, out_res;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format_mode    <= 1'b0;
      cfg_q.cue_type_code  <= 8'd1;
      cfg_q.loop_type_code <= 8'd3;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_FORMAT_MODE: cfg_q.format_mode    <= pwdata[0];
        REG_CUE_TYPE:    cfg_q.cue_type_code  <= pwdata[7:0];
        REG_LOOP_TYPE:   cfg_q.loop_type_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_FORMAT_MODE: prdata = {31'd0, cfg_q.format_mode};
      REG_CUE_TYPE:    prdata = {24'd0, cfg_q.cue_type_code};
      REG_LOOP_TYPE:   prdata = {24'd0, cfg_q.loop_type_code};
      default:         prdata = '0;
    endcase
  end

  assign s_axis_tready = buf_ready;
  assign advance       = s_axis_tvalid && buf_ready;

  cmtp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .advance_i   (advance),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cmtp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (buf_ready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = out_res.result_kind;
  assign m_axis_tdata = {5'd0, out_res.error_code, out_res.track_color, out_res.locked_flag,
                         out_res.type_code, out_res.marker_color, out_res.end_position,
                         out_res.has_end, out_res.start_position, out_res.has_start,
                         out_res.slot_index};

  a_out_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_ENTRY || m_axis_tuser == KIND_DONE ||
                       m_axis_tuser == KIND_ERROR))
    else $error("output carries an unused result kind");

  a_err_code_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.result_kind != KIND_ERROR |-> out_res.error_code == ERR_NONE)
    else $error("error code set on a non-error result");

endmodule

// ----- hdl/cmtp_parser.sv -----
// tag parsing state and per-byte decode of header, entries and trailer
module cmtp_parser
  import cmtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       advance_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ENTRY   = 3'd1,
    PH_TRAILER = 3'd2,
    PH_DONE    = 3'd3,
    PH_SKIP    = 3'd4
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [31:0]         shift_q, shift_d;
  logic [7:0]          ent_q [ENTRY_PACKED];
  logic [7:0]          ev [ENTRY_PACKED];

  logic [31:0]       shift_in;
  logic [CNT_W:0]    entry_size;
  logic [SLOT_W-1:0] slot_nx;
  logic [31:0]       rs, re;
  logic [7:0]        typ, lock;
  logic              hs, he, lock_bad, start_bad, end_bad, filler_bad, slot_bad;
  logic [31:0]       sp, ep;
  logic [23:0]       col, tc;
  logic              err, restart;
  err_code_e         ecode;
  logic              res_v;
  res_t              res;

  // entry bytes with the current byte already in place
  always_comb begin
    for (int i = 0; i < ENTRY_PACKED; i++) begin
      ev[i] = (cnt_q == CNT_W'(i)) ? data_byte_i : ent_q[i];
    end
  end

  always_comb begin
    shift_in   = {shift_q[23:0], data_byte_i};
    entry_size = cfg_i.format_mode ? (CNT_W+1)'(ENTRY_PLAIN) : (CNT_W+1)'(ENTRY_PACKED);
    slot_nx    = slot_q + 1'b1;
    rs         = {ev[1], ev[2], ev[3], ev[4]};
    re         = {ev[6], ev[7], ev[8], ev[9]};
    if (!cfg_i.format_mode) begin
      typ        = ev[20];
      lock       = ev[21];
      hs         = ev[0] != ABSENT_MARK;
      he         = ev[5] != ABSENT_MARK;
      start_bad  = !hs && (rs != NO_POS);
      end_bad    = !he && (re != NO_POS);
      filler_bad = ev[10] != 8'h00;
      sp         = hs ? {8'h00, unpack24(ev[1], ev[2], ev[3], ev[4])} : NO_POS;
      ep         = he ? {8'h00, unpack24(ev[6], ev[7], ev[8], ev[9])} : NO_POS;
      col        = unpack24(ev[16], ev[17], ev[18], ev[19]);
      tc         = unpack24(shift_in[31:24], shift_in[23:16], shift_in[15:8], shift_in[7:0]);
    end else begin
      typ        = ev[17];
      lock       = ev[18];
      hs         = 1'b1;
      he         = ev[17] == cfg_i.loop_type_code;
      start_bad  = 1'b0;
      end_bad    = 1'b0;
      filler_bad = ev[8] != 8'h00;
      sp         = {ev[0], ev[1], ev[2], ev[3]};
      ep         = {ev[4], ev[5], ev[6], ev[7]};
      col        = {ev[14], ev[15], ev[16]};
      tc         = shift_in[23:0];
    end
    lock_bad = (lock != 8'h00) && (typ != cfg_i.loop_type_code);
    slot_bad = (slot_q < SLOT_W'(CUE_SLOTS)) ? (typ != cfg_i.cue_type_code)
                                             : (typ != cfg_i.loop_type_code);
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    slot_d  = slot_q;
    shift_d = shift_q;
    err     = 1'b0;
    ecode   = ERR_NONE;
    restart = 1'b0;
    res_v   = 1'b0;
    res     = '0;

    unique case (phase_q)
      PH_SKIP: begin
        if (last_byte_i) restart = 1'b1;
      end
      PH_HEADER: begin
        shift_d = shift_in;
        if (cnt_q == CNT_W'(1) && shift_in[15:0] != TAG_VERSION) begin
          err   = 1'b1;
          ecode = ERR_VERSION;
        end else if (cnt_q >= CNT_W'(HDR_LAST)) begin
          if (shift_in != 32'(TOTAL_SLOTS)) begin
            err   = 1'b1;
            ecode = ERR_COUNT;
          end else begin
            cnt_d   = '0;
            slot_d  = '0;
            phase_d = PH_ENTRY;
            if (last_byte_i) begin
              err   = 1'b1;
              ecode = ERR_TRUNC;
            end
          end
        end else if (last_byte_i) begin
          err   = 1'b1;
          ecode = (cnt_q == '0) ? ERR_VERSION : ERR_COUNT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      PH_ENTRY: begin
        if ({1'b0, cnt_q} + 1'b1 < entry_size) begin
          if (last_byte_i) begin
            err   = 1'b1;
            ecode = ERR_TRUNC;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          // fault order: lock, start, end, filler, slot type
          priority if (lock_bad) begin
            err   = 1'b1;
            ecode = ERR_LOCK;
          end else if (start_bad) begin
            err   = 1'b1;
            ecode = ERR_START;
          end else if (end_bad) begin
            err   = 1'b1;
            ecode = ERR_END;
          end else if (filler_bad) begin
            err   = 1'b1;
            ecode = ERR_FILLER;
          end else if (slot_bad) begin
            err   = 1'b1;
            ecode = ERR_SLOT;
          end else begin
            res_v              = 1'b1;
            res.result_kind    = KIND_ENTRY;
            res.slot_index     = 4'(slot_q);
            res.has_start      = hs;
            res.start_position = sp;
            res.has_end        = he;
            res.end_position   = ep;
            res.marker_color   = col;
            res.type_code      = typ;
            res.locked_flag    = lock != 8'h00;
            slot_d             = slot_nx;
            cnt_d              = '0;
            if (slot_nx >= SLOT_W'(TOTAL_SLOTS)) begin
              phase_d = PH_TRAILER;
              shift_d = '0;
            end
            if (last_byte_i) begin
              err   = 1'b1;
              ecode = ERR_TRUNC;
            end
          end
        end
      end
      PH_TRAILER: begin
        shift_d = shift_in;
        if (cfg_i.format_mode && cnt_q == '0 && data_byte_i != 8'h00) begin
          err   = 1'b1;
          ecode = ERR_PAD;
        end else if (cnt_q >= CNT_W'(TRL_LAST)) begin
          if (last_byte_i) begin
            res_v           = 1'b1;
            res.result_kind = KIND_DONE;
            res.track_color = tc;
            restart         = 1'b1;
          end else begin
            phase_d = PH_DONE;
          end
        end else if (last_byte_i) begin
          err   = 1'b1;
          ecode = ERR_TRUNC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      PH_DONE: begin
        err   = 1'b1;
        ecode = ERR_TRAILING;
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (err) begin
      res_v           = 1'b1;
      res             = '0;
      res.result_kind = KIND_ERROR;
      res.error_code  = ecode;
      if (last_byte_i) restart = 1'b1;
      else phase_d = PH_SKIP;
    end
    if (restart) begin
      phase_d = PH_HEADER;
      cnt_d   = '0;
      slot_d  = '0;
      shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      slot_q  <= '0;
      shift_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      slot_q  <= slot_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && phase_q == PH_ENTRY && cnt_q < CNT_W'(ENTRY_PACKED)) begin
      ent_q[cnt_q] <= data_byte_i;
    end
  end

  assign res_valid_o = advance_i && res_v;
  assign res_o       = res;

  a_err_not_last_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_kind == KIND_ERROR && !last_byte_i |=> phase_q == PH_SKIP)
    else $error("error on a non-last byte did not enter skip");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(TOTAL_SLOTS))
    else $error("slot counter past the table");

  a_entry_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ENTRY |-> cnt_q < CNT_W'(ENTRY_PACKED))
    else $error("entry byte counter past the largest entry");

  a_last_ends_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last_byte_i |=> phase_q == PH_HEADER && cnt_q == '0)
    else $error("last byte did not restart the header");

endmodule

// ----- hdl/cmtp_out_buf.sv -----
// result register with one skid entry toward the output stream
module cmtp_out_buf
  import cmtp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  res_t in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output res_t out_data_o,
  input  logic out_ready_i
);

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_ready_i || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_valid_i;
      end
    end else if (in_valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : in_data_i;
    end else if (in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held with empty output register");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !in_valid_i)
    else $error("result offered while skid entry is full");

endmodule

// ----- test/testbench.sv -----
// self-checking stream testbench for the cue marker tag parser
`timescale 1ns / 100ps

module testbench;
  import cmtp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ENTRY,
    PH_TRAILER,
    PH_DONE,
    PH_SKIP
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tag_byte_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [3:0] slot_index, [4] has_start, [36:5] start_position, [37] has_end,
  // [69:38] end_position, [93:70] marker_color, [101:94] type_code,
  // [102] locked_flag, [126:103] track_color, [130:127] error_code
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;           // [1:0] result_kind
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = 4'h0;
  logic [31:0]  pwdata = 32'h0;
  logic [31:0]  prdata;
  logic         pready;

  cue_marker_tag_parser dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tag_byte_t    tag_bytes_q[$];
  res_t         tag_results_q[$];
  logic [7:0]   tag_buf[$];
  int unsigned  mismatches = 0;
  int unsigned  src_idle_pct = 20;
  int unsigned  sink_idle_pct = 20;
  int unsigned  src_gap = 0;
  int unsigned  sink_gap = 0;
  bit           byte_taken = 1'b0;

  // parser state as seen from outside
  cfg_t         regs;
  parse_phase_e ph = PH_HEADER;
  int unsigned  byte_cnt = 0;
  int unsigned  slot_cnt = 0;
  logic [47:0]  hdr_shift = '0;
  logic [7:0]   ent [0:ENTRY_PACKED-1];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  // 7-bit groups, high bits of the first byte beyond bit 2 are lost
  function automatic logic [23:0] fold7(input logic [7:0] w, input logic [7:0] x,
                                        input logic [7:0] y, input logic [7:0] z);
    return {w[2:0], x[6:0], y[6:0], z[6:0]};
  endfunction

  function automatic void restart_parse();
    ph = PH_HEADER;
    byte_cnt = 0;
    slot_cnt = 0;
    hdr_shift = '0;
  endfunction

  function automatic void reject(input err_code_e code, input bit last);
    res_t r;
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code = code;
    tag_results_q.push_back(r);
    if (last) restart_parse();
    else ph = PH_SKIP;
  endfunction

  function automatic void parse_tag_byte(input logic [7:0] d, input bit last);
    res_t        r;
    err_code_e   err;
    int unsigned n;
    int unsigned size;
    logic [7:0]  typ;
    logic [7:0]  lock;
    logic [31:0] raw_s;
    logic [31:0] raw_e;
    logic [31:0] v;
    logic [23:0] tc;
    logic        hs;
    logic        he;
    n = byte_cnt;
    r = '0;
    err = ERR_NONE;
    case (ph)
      PH_SKIP: if (last) restart_parse();
      PH_HEADER: begin
        hdr_shift = {hdr_shift[39:0], d};
        if (n == 1 && hdr_shift[15:0] != TAG_VERSION) begin
          reject(ERR_VERSION, last);
        end else if (n >= HDR_LAST) begin
          if (hdr_shift[31:0] != 32'(TOTAL_SLOTS)) begin
            reject(ERR_COUNT, last);
          end else begin
            byte_cnt = 0;
            slot_cnt = 0;
            ph = PH_ENTRY;
            if (last) reject(ERR_TRUNC, last);
          end
        end else if (last) begin
          reject(n == 0 ? ERR_VERSION : ERR_COUNT, last);
        end else begin
          byte_cnt = n + 1;
        end
      end
      PH_ENTRY: begin
        size = regs.format_mode ? ENTRY_PLAIN : ENTRY_PACKED;
        if (n < ENTRY_PACKED) ent[n] = d;
        if (n + 1 < size) begin
          if (last) reject(ERR_TRUNC, last);
          else byte_cnt = n + 1;
        end else begin
          if (!regs.format_mode) begin
            raw_s = {ent[1], ent[2], ent[3], ent[4]};
            raw_e = {ent[6], ent[7], ent[8], ent[9]};
            typ = ent[20];
            lock = ent[21];
            hs = ent[0] != ABSENT_MARK;
            he = ent[5] != ABSENT_MARK;
            if (lock != 0 && typ != regs.loop_type_code) err = ERR_LOCK;
            else if (!hs && raw_s != NO_POS) err = ERR_START;
            else if (!he && raw_e != NO_POS) err = ERR_END;
            else if (ent[10] != 0) err = ERR_FILLER;
            r.start_position = hs ? {8'h00, fold7(ent[1], ent[2], ent[3], ent[4])} : NO_POS;
            r.end_position = he ? {8'h00, fold7(ent[6], ent[7], ent[8], ent[9])} : NO_POS;
            r.marker_color = fold7(ent[16], ent[17], ent[18], ent[19]);
          end else begin
            typ = ent[17];
            lock = ent[18];
            hs = 1'b1;
            he = typ == regs.loop_type_code;
            if (lock != 0 && typ != regs.loop_type_code) err = ERR_LOCK;
            else if (ent[8] != 0) err = ERR_FILLER;
            r.start_position = {ent[0], ent[1], ent[2], ent[3]};
            r.end_position = {ent[4], ent[5], ent[6], ent[7]};
            r.marker_color = {ent[14], ent[15], ent[16]};
          end
          // cue slots come first, then loop slots
          if (err == ERR_NONE &&
              typ != (slot_cnt < CUE_SLOTS ? regs.cue_type_code : regs.loop_type_code))
            err = ERR_SLOT;
          if (err != ERR_NONE) begin
            reject(err, last);
          end else begin
            r.result_kind = KIND_ENTRY;
            r.slot_index = 4'(slot_cnt);
            r.has_start = hs;
            r.has_end = he;
            r.type_code = typ;
            r.locked_flag = lock != 0;
            slot_cnt = slot_cnt + 1;
            byte_cnt = 0;
            if (slot_cnt >= TOTAL_SLOTS) begin
              ph = PH_TRAILER;
              hdr_shift = '0;
            end
            // a clean entry on the last byte still counts as truncation
            if (last) reject(ERR_TRUNC, last);
            else tag_results_q.push_back(r);
          end
        end
      end
      PH_TRAILER: begin
        hdr_shift = {16'h0000, hdr_shift[23:0], d};
        if (regs.format_mode && n == 0 && d != 0) begin
          reject(ERR_PAD, last);
        end else if (n >= TRL_LAST) begin
          v = hdr_shift[31:0];
          tc = regs.format_mode ? v[23:0] : fold7(v[31:24], v[23:16], v[15:8], v[7:0]);
          if (last) begin
            r.result_kind = KIND_DONE;
            r.track_color = tc;
            tag_results_q.push_back(r);
            restart_parse();
          end else begin
            ph = PH_DONE;
          end
        end else if (last) begin
          reject(ERR_TRUNC, last);
        end else begin
          byte_cnt = n + 1;
        end
      end
      PH_DONE: reject(ERR_TRAILING, last);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches = mismatches + 1;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (tag_results_q.size() == 0) begin
      $error("unexpected result of kind %0d", m_axis_tuser);
      mismatches = mismatches + 1;
    end else begin
      want = tag_results_q.pop_front();
      check_field("result_kind", 32'(want.result_kind), 32'(m_axis_tuser));
      check_field("slot_index", 32'(want.slot_index), 32'(m_axis_tdata[3:0]));
      check_field("has_start", 32'(want.has_start), 32'(m_axis_tdata[4]));
      check_field("start_position", want.start_position, m_axis_tdata[36:5]);
      check_field("has_end", 32'(want.has_end), 32'(m_axis_tdata[37]));
      check_field("end_position", want.end_position, m_axis_tdata[69:38]);
      check_field("marker_color", 32'(want.marker_color), 32'(m_axis_tdata[93:70]));
      check_field("type_code", 32'(want.type_code), 32'(m_axis_tdata[101:94]));
      check_field("locked_flag", 32'(want.locked_flag), 32'(m_axis_tdata[102]));
      check_field("track_color", 32'(want.track_color), 32'(m_axis_tdata[126:103]));
      check_field("error_code", 32'(want.error_code), 32'(m_axis_tdata[130:127]));
      check_field("tdata padding", 32'h0, 32'(m_axis_tdata[135:131]));
    end
  endfunction

  // byte source: holds a byte until its transfer, idles in bursts
  always @(negedge clk_i) begin
    if (byte_taken || !s_axis_tvalid) begin
      byte_taken = 1'b0;
      if (src_gap != 0) begin
        src_gap = src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if ($urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(0, 12);
        s_axis_tvalid <= 1'b0;
      end else if (tag_bytes_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tag_bytes_q[0].data;
        s_axis_tlast <= tag_bytes_q[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with stall bursts
  always @(negedge clk_i) begin
    if (sink_gap != 0) begin
      sink_gap = sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      sink_gap = $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // results are checked before the byte of this edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        parse_tag_byte(s_axis_tdata, s_axis_tlast);
        void'(tag_bytes_q.pop_front());
        byte_taken = 1'b1;
      end
    end
  end

  function automatic void queue_byte(input logic [7:0] d, input bit last);
    tag_byte_t b;
    b.data = d;
    b.last = last;
    tag_bytes_q.push_back(b);
  endfunction

  function automatic void push_bytes(input int unsigned from, input int unsigned upto,
                                     input bit end_tag);
    for (int unsigned i = from; i < upto; i++)
      queue_byte(tag_buf[i], end_tag && i == upto - 1);
  endfunction

  task automatic settle();
    while (tag_bytes_q.size() != 0 || tag_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FORMAT_MODE: regs.format_mode = val[0];
      REG_CUE_TYPE:    regs.cue_type_code = val[7:0];
      REG_LOOP_TYPE:   regs.loop_type_code = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic fmt, input logic [7:0] cue, input logic [7:0] loop);
    reg_write(REG_FORMAT_MODE, {31'h0, fmt});
    reg_write(REG_CUE_TYPE, {24'h0, cue});
    reg_write(REG_LOOP_TYPE, {24'h0, loop});
  endtask

  // well-formed tag with random content for the current register values
  function automatic void build_tag();
    logic [31:0] count;
    logic [7:0]  typ;
    logic [7:0]  st;
    tag_buf.delete();
    count = TOTAL_SLOTS;
    tag_buf.push_back(TAG_VERSION[15:8]);
    tag_buf.push_back(TAG_VERSION[7:0]);
    for (int i = 3; i >= 0; i--) tag_buf.push_back(count[8*i +: 8]);
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      typ = s < CUE_SLOTS ? regs.cue_type_code : regs.loop_type_code;
      if (regs.format_mode) begin
        repeat (8) tag_buf.push_back(8'($urandom_range(0, 255)));
        tag_buf.push_back(8'h00);
        repeat (4)
          tag_buf.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'hFF);
        tag_buf.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
        repeat (3) tag_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat (2) begin
          if ($urandom_range(0, 3) == 0) begin
            repeat (5) tag_buf.push_back(ABSENT_MARK);
          end else begin
            st = 8'($urandom_range(0, 255));
            tag_buf.push_back(st == ABSENT_MARK ? 8'h00 : st);
            repeat (4) tag_buf.push_back(8'($urandom_range(0, 255)));
          end
        end
        tag_buf.push_back(8'h00);
        repeat (5)
          tag_buf.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h7F);
        repeat (4) tag_buf.push_back(8'($urandom_range(0, 255)));
      end
      tag_buf.push_back(typ);
      tag_buf.push_back(typ == regs.loop_type_code ? 8'($urandom_range(0, 255)) : 8'h00);
    end
    if (regs.format_mode) begin
      tag_buf.push_back(8'h00);
      repeat (3) tag_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (4) tag_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // plants at most one fault in the built tag, returns how many bytes to send
  function automatic int unsigned spoil_tag();
    err_code_e   flaw;
    int unsigned size;
    int unsigned base;
    int unsigned at;
    int unsigned pos;
    int unsigned len;
    size = regs.format_mode ? ENTRY_PLAIN : ENTRY_PACKED;
    base = HDR_LAST + 1 + $urandom_range(0, TOTAL_SLOTS - 1) * size;
    at = base + size - 1;
    len = tag_buf.size();
    flaw = err_code_e'($urandom_range(ERR_VERSION, ERR_PAD));
    case (flaw)
      ERR_VERSION: begin
        at = $urandom_range(0, 1);
        tag_buf[at] = tag_buf[at] ^ 8'($urandom_range(1, 255));
      end
      ERR_COUNT: begin
        at = $urandom_range(2, HDR_LAST);
        tag_buf[at] = tag_buf[at] ^ 8'($urandom_range(1, 255));
      end
      ERR_START, ERR_END: begin
        pos = base + (flaw == ERR_END ? (regs.format_mode ? 4 : 5) : 0);
        if (!regs.format_mode) begin
          // absent marker; in three of four cases the raw value is not all 0x7f
          for (int i = 0; i <= 4; i++) tag_buf[pos + i] = ABSENT_MARK;
          if ($urandom_range(0, 3) != 0)
            tag_buf[pos + $urandom_range(1, 4)] = ABSENT_MARK ^ 8'($urandom_range(1, 255));
        end else begin
          tag_buf[pos + $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
        end
      end
      ERR_FILLER: tag_buf[base + (regs.format_mode ? 8 : 10)] = 8'($urandom_range(1, 255));
      ERR_LOCK: begin
        tag_buf[at] = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) tag_buf[at - 1] = 8'($urandom_range(0, 255));
      end
      ERR_SLOT: tag_buf[at - 1] = 8'($urandom_range(0, 255));
      ERR_TRUNC: if ($urandom_range(0, 1)) at = $urandom_range(0, len - 2);
      ERR_TRAILING: begin
        repeat ($urandom_range(1, 3)) tag_buf.push_back(8'($urandom_range(0, 255)));
        len = tag_buf.size();
        at = len - 1;
      end
      ERR_PAD: begin
        at = len - 4;
        tag_buf[at] = 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    if (flaw == ERR_TRUNC) len = at + 1;
    else if ($urandom_range(0, 1) && at + 4 < len) len = at + 1 + $urandom_range(0, 3);
    return len;
  endfunction

  task automatic run_phase(input int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        len = $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++)
          queue_byte(8'($urandom_range(0, 255)), i == len - 1);
      end else begin
        build_tag();
        len = pick < 5 ? tag_buf.size() : spoil_tag();
        push_bytes(0, len, 1'b1);
      end
      sent = sent + len;
    end
    settle();
  endtask

  // layout switched while an entry is half received
  task automatic split_tag(input logic new_fmt);
    int unsigned cut;
    build_tag();
    cut = HDR_LAST + 1 + (regs.format_mode ? ENTRY_PLAIN : ENTRY_PACKED) + $urandom_range(12, 21);
    push_bytes(0, cut, 1'b0);
    settle();
    reg_write(REG_FORMAT_MODE, {31'h0, new_fmt});
    push_bytes(cut, cut + ENTRY_PACKED + 2, 1'b1);
    settle();
  endtask

  initial begin
    regs.format_mode = 1'b0;
    regs.cue_type_code = 8'd1;
    regs.loop_type_code = 8'd3;
    for (int i = 0; i < ENTRY_PACKED; i++) ent[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // tag ending on its first byte
    queue_byte(8'h02, 1'b1);
    // bad version on a last byte
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h06, 1'b1);
    // tag ending right after the version, before the count
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h05, 1'b1);
    // bad version, rest of the tag dropped
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b1);
    // header alone
    queue_byte(TAG_VERSION[15:8], 1'b0);
    queue_byte(TAG_VERSION[7:0], 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'(TOTAL_SLOTS), 1'b1);
    // wrong count, on a last byte and then mid-tag
    queue_byte(TAG_VERSION[15:8], 1'b0);
    queue_byte(TAG_VERSION[7:0], 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'(TOTAL_SLOTS + 1), 1'b1);
    queue_byte(TAG_VERSION[15:8], 1'b0);
    queue_byte(TAG_VERSION[7:0], 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    settle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: program_regs(1'b0, 8'd1, 8'd3);
        1: program_regs(1'b1, 8'd1, 8'd3);
        2: program_regs(1'b0, 8'h00, 8'hFF);
        3: program_regs(1'b1, 8'hFF, 8'h00);
        4: program_regs(1'b0, 8'h5A, 8'h5A);
        5: program_regs(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: program_regs(1'($urandom_range(0, 1)), 8'd1, 8'd3);
      endcase
      case ($urandom_range(0, 2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 10;
        default: src_idle_pct = 35;
      endcase
      sink_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 35);
      // no idling at all in the last part
      if (p == 6) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (p == 2) split_tag(1'b1);
      if (p == 3) split_tag(1'b0);
      run_phase(60);
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/cmtp_pkg.sv
hdl/cmtp_parser.sv
hdl/cmtp_out_buf.sv
hdl/cue_marker_tag_parser.sv
test/testbench.sv
